[rtl/sprd_pkg.sv]
// ----------------------------------------------------------------------------
// sprd_pkg : shared types and constants of the sprite RLE pixel decoder
// Sequencer states, stream phases, event codes, register map and reset values.
// ----------------------------------------------------------------------------
package sprd_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_EXEC,
    S_DIV,
    S_EMIT
  } sprd_state_t;

  // stream phase within a run pair
  localparam logic [2:0] PH_TRANS_LO = 3'd0;
  localparam logic [2:0] PH_TRANS_HI = 3'd1;
  localparam logic [2:0] PH_COLR_LO  = 3'd2;
  localparam logic [2:0] PH_COLR_HI  = 3'd3;
  localparam logic [2:0] PH_RED      = 3'd4;
  localparam logic [2:0] PH_GREEN    = 3'd5;
  localparam logic [2:0] PH_BLUE     = 3'd6;

  // event codes
  localparam logic [1:0] EV_PIXEL     = 2'd0;
  localparam logic [1:0] EV_FRAME_END = 2'd1;
  localparam logic [1:0] EV_TRANS_OVF = 2'd2;
  localparam logic [1:0] EV_COLR_OVF  = 2'd3;

  // register map, word index
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [7:0]  RST_WIDTH  = 8'd32;
  localparam logic [7:0]  RST_HEIGHT = 8'd32;
  localparam logic [11:0] RST_COUNT  = 12'd1;

  // position / width divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 16;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
    logic [7:0] rem;
  } sprd_div_res_t;

endpackage

[rtl/sprd_div.sv]
// ----------------------------------------------------------------------------
// sprd_div : iterative restoring divider
// 16-bit position by 8-bit width, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module sprd_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [15:0]            dividend,
  input  logic [7:0]             divisor,
  output sprd_pkg::sprd_div_res_t res
);

  localparam int unsigned CntW = $clog2(sprd_pkg::DIV_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(sprd_pkg::DIV_STEPS - 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [15:0]     quo_r, quo_nxt;
  logic [7:0]      dvs_r, dvs_nxt;
  logic [8:0]      shifted;
  logic [8:0]      diff;
  logic            fits;

  assign shifted = {rem_r, quo_r[15]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so 8 bits suffice
      rem_nxt = fits ? diff[7:0] : shifted[7:0];
      quo_nxt = {quo_r[14:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntLast) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r[7:0];
  assign res.rem  = rem_r;

endmodule

[rtl/sprite_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// sprite_rle_pixel_decoder : run-length sprite pixel stream decoder
// Walks transparent/coloured run pairs and RGB triples, emitting pixel writes
// with x/y placement, end-of-frame marks and run overflow errors.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat
//  in_*      sink       in_valid / in_stall   one stream byte + start flag
//  out_*     source     out_valid / out_stall one event (pixel, frame end, error)
//  cfg/APB   sink       psel/penable/pready   one 32-bit register access
//
//  - A byte passes through take, frame size and execute; a blue byte adds the
//    bit-serial position/width divide that places the pixel.
//  - A beat that raises an event passes through S_EMIT to load the output
//    register, and waits there while a previous event is still held by out_stall.
//  - in_stall is low only when the sequencer is idle; the output register
//    decouples the result side, so a new byte is taken while an event waits.
//  - Synchronous active-low reset: registers back to 32 x 32, one frame,
//    all decode progress cleared.
//
module sprite_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_sprite,
  // events
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_frame_number,
  output logic        out_frame_done,
  output logic        out_sprite_done,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [11:0] img_count_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= sprd_pkg::RST_WIDTH;
      height_r    <= sprd_pkg::RST_HEIGHT;
      img_count_r <= sprd_pkg::RST_COUNT;
    end else if (cfg_wr) begin
      case (reg_idx)
        sprd_pkg::REG_WIDTH:  width_r     <= pwdata[7:0];
        sprd_pkg::REG_HEIGHT: height_r    <= pwdata[7:0];
        sprd_pkg::REG_COUNT:  img_count_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sprd_pkg::REG_WIDTH:  prdata = {24'd0, width_r};
      sprd_pkg::REG_HEIGHT: prdata = {24'd0, height_r};
      sprd_pkg::REG_COUNT:  prdata = {20'd0, img_count_r};
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and decode state
  // --------------------------------------------------------------------------
  sprd_pkg::sprd_state_t state_r, state_nxt;

  logic        in_take;
  logic        out_free;
  logic        out_load;
  logic        div_start;
  logic        exec_div;    // blue byte: launch placement divide
  logic        exec_emit;   // this byte raises an event straight away

  logic [7:0]  byte_r;
  logic [15:0] fsize_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] trans_r, trans_nxt;
  logic [15:0] colr_r, colr_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [11:0] fc_r, fc_nxt;
  logic [7:0]  held_red_r, held_red_nxt;
  logic [7:0]  held_grn_r, held_grn_nxt;
  logic        err_r, err_nxt;

  // pending event, waiting for the output register
  logic [1:0]  pend_kind_r, pend_kind_nxt;
  logic [7:0]  pend_x_r, pend_x_nxt;
  logic [7:0]  pend_y_r, pend_y_nxt;
  logic [7:0]  pend_red_r, pend_red_nxt;
  logic [7:0]  pend_grn_r, pend_grn_nxt;
  logic [7:0]  pend_blu_r, pend_blu_nxt;
  logic [11:0] pend_fn_r, pend_fn_nxt;
  logic        pend_fd_r, pend_fd_nxt;
  logic        pend_sd_r, pend_sd_nxt;

  logic        out_valid_r;

  // shared arithmetic of the execute step
  logic [15:0] colr_full;
  logic [16:0] run_sum;
  logic [15:0] pos_inc;
  logic [15:0] colr_dec;
  logic        sprite_end;
  logic        halted;

  sprd_pkg::sprd_div_res_t div_res;

  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign colr_full  = {byte_r, colr_r[7:0]};
  assign run_sum    = {1'b0, pos_r} + {1'b0, trans_r};
  assign pos_inc    = pos_r + 16'd1;
  assign colr_dec   = colr_r - 16'd1;
  assign sprite_end = ({1'b0, fc_r} + 13'd1) >= {1'b0, img_count_r};
  assign halted     = err_r || (fc_r >= img_count_r);

  sprd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_r),
    .divisor  (width_r),
    .res      (div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sprd_pkg::S_IDLE: if (in_valid) state_nxt = sprd_pkg::S_SIZE;
      sprd_pkg::S_SIZE: state_nxt = sprd_pkg::S_EXEC;
      sprd_pkg::S_EXEC: begin
        if (exec_div)       state_nxt = sprd_pkg::S_DIV;
        else if (exec_emit) state_nxt = sprd_pkg::S_EMIT;
        else                state_nxt = sprd_pkg::S_IDLE;
      end
      sprd_pkg::S_DIV:  if (div_res.done) state_nxt = sprd_pkg::S_EMIT;
      sprd_pkg::S_EMIT: if (out_free) state_nxt = sprd_pkg::S_IDLE;
      default:          state_nxt = sprd_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != sprd_pkg::S_IDLE);
    div_start = (state_r == sprd_pkg::S_EXEC) && exec_div;
    out_load  = (state_r == sprd_pkg::S_EMIT) && out_free;
  end

  // decode step: one byte of the stream per pass through S_EXEC
  always_comb begin
    phase_nxt     = phase_r;
    trans_nxt     = trans_r;
    colr_nxt      = colr_r;
    pos_nxt       = pos_r;
    fc_nxt        = fc_r;
    held_red_nxt  = held_red_r;
    held_grn_nxt  = held_grn_r;
    err_nxt       = err_r;
    pend_kind_nxt = pend_kind_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_red_nxt  = pend_red_r;
    pend_grn_nxt  = pend_grn_r;
    pend_blu_nxt  = pend_blu_r;
    pend_fn_nxt   = pend_fn_r;
    pend_fd_nxt   = pend_fd_r;
    pend_sd_nxt   = pend_sd_r;
    exec_div      = 1'b0;
    exec_emit     = 1'b0;

    if (in_take && in_start_sprite) begin
      // new sprite: forget all progress, this byte is its first
      phase_nxt    = sprd_pkg::PH_TRANS_LO;
      trans_nxt    = '0;
      colr_nxt     = '0;
      pos_nxt      = '0;
      fc_nxt       = '0;
      held_red_nxt = '0;
      held_grn_nxt = '0;
      err_nxt      = 1'b0;
    end

    if (state_r == sprd_pkg::S_EXEC && !halted) begin
      // non-pixel events carry zero placement and colour
      pend_x_nxt   = '0;
      pend_y_nxt   = '0;
      pend_red_nxt = '0;
      pend_grn_nxt = '0;
      pend_blu_nxt = '0;
      pend_fn_nxt  = fc_r;
      pend_fd_nxt  = 1'b0;
      pend_sd_nxt  = 1'b0;
      case (phase_r)
        sprd_pkg::PH_TRANS_LO: begin
          trans_nxt = {8'd0, byte_r};
          phase_nxt = sprd_pkg::PH_TRANS_HI;
        end
        sprd_pkg::PH_TRANS_HI: begin
          trans_nxt = {byte_r, trans_r[7:0]};
          phase_nxt = sprd_pkg::PH_COLR_LO;
        end
        sprd_pkg::PH_COLR_LO: begin
          colr_nxt  = {8'd0, byte_r};
          phase_nxt = sprd_pkg::PH_COLR_HI;
        end
        sprd_pkg::PH_COLR_HI: begin
          colr_nxt  = colr_full;
          phase_nxt = sprd_pkg::PH_TRANS_LO;
          if (run_sum > {1'b0, fsize_r}) begin
            // transparent run overshoots the frame
            exec_emit     = 1'b1;
            pend_kind_nxt = sprd_pkg::EV_TRANS_OVF;
            err_nxt       = 1'b1;
          end else begin
            pos_nxt = run_sum[15:0];
            if (colr_full == 16'd0) begin
              if (run_sum[15:0] == fsize_r) begin
                // empty pair that exactly fills the frame
                exec_emit     = 1'b1;
                pend_kind_nxt = sprd_pkg::EV_FRAME_END;
                pend_fd_nxt   = 1'b1;
                pend_sd_nxt   = sprite_end;
                fc_nxt        = fc_r + 12'd1;
                pos_nxt       = '0;
              end
            end else if (run_sum[15:0] >= fsize_r) begin
              // coloured run starting at a full frame
              exec_emit     = 1'b1;
              pend_kind_nxt = sprd_pkg::EV_COLR_OVF;
              err_nxt       = 1'b1;
            end else begin
              phase_nxt = sprd_pkg::PH_RED;
            end
          end
        end
        sprd_pkg::PH_RED: begin
          if (pos_r >= fsize_r) begin
            exec_emit     = 1'b1;
            pend_kind_nxt = sprd_pkg::EV_COLR_OVF;
            err_nxt       = 1'b1;
            phase_nxt     = sprd_pkg::PH_TRANS_LO;
          end else begin
            held_red_nxt = byte_r;
            phase_nxt    = sprd_pkg::PH_GREEN;
          end
        end
        sprd_pkg::PH_GREEN: begin
          held_grn_nxt = byte_r;
          phase_nxt    = sprd_pkg::PH_BLUE;
        end
        sprd_pkg::PH_BLUE: begin
          if (pos_r >= fsize_r) begin
            exec_emit     = 1'b1;
            pend_kind_nxt = sprd_pkg::EV_COLR_OVF;
            err_nxt       = 1'b1;
            phase_nxt     = sprd_pkg::PH_TRANS_LO;
          end else begin
            // pixel: divider places it from the pre-increment position
            exec_div      = 1'b1;
            pend_kind_nxt = sprd_pkg::EV_PIXEL;
            pend_red_nxt  = held_red_r;
            pend_grn_nxt  = held_grn_r;
            pend_blu_nxt  = byte_r;
            pos_nxt       = pos_inc;
            colr_nxt      = colr_dec;
            if (colr_dec == 16'd0) begin
              phase_nxt = sprd_pkg::PH_TRANS_LO;
              if (pos_inc == fsize_r) begin
                pend_fd_nxt = 1'b1;
                pend_sd_nxt = sprite_end;
                fc_nxt      = fc_r + 12'd1;
                pos_nxt     = '0;
              end
            end else begin
              phase_nxt = sprd_pkg::PH_RED;
            end
          end
        end
        default: phase_nxt = sprd_pkg::PH_TRANS_LO;
      endcase
    end

    if (state_r == sprd_pkg::S_DIV && div_res.done) begin
      pend_x_nxt = (width_r == 8'd0) ? 8'd0 : div_res.rem;
      pend_y_nxt = (width_r == 8'd0) ? 8'd0 : div_res.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sprd_pkg::S_IDLE;
      phase_r     <= sprd_pkg::PH_TRANS_LO;
      trans_r     <= '0;
      colr_r      <= '0;
      pos_r       <= '0;
      fc_r        <= '0;
      held_red_r  <= '0;
      held_grn_r  <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      trans_r    <= trans_nxt;
      colr_r     <= colr_nxt;
      pos_r      <= pos_nxt;
      fc_r       <= fc_nxt;
      held_red_r <= held_red_nxt;
      held_grn_r <= held_grn_nxt;
      err_r      <= err_nxt;
      if (out_load)            out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take)                     byte_r  <= in_data_byte;
    if (state_r == sprd_pkg::S_SIZE) fsize_r <= {8'd0, width_r} * {8'd0, height_r};
    pend_kind_r <= pend_kind_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_red_r  <= pend_red_nxt;
    pend_grn_r  <= pend_grn_nxt;
    pend_blu_r  <= pend_blu_nxt;
    pend_fn_r   <= pend_fn_nxt;
    pend_fd_r   <= pend_fd_nxt;
    pend_sd_r   <= pend_sd_nxt;
    if (out_load) begin
      out_event_kind   <= pend_kind_r;
      out_pixel_x      <= pend_x_r;
      out_pixel_y      <= pend_y_r;
      out_red          <= pend_red_r;
      out_green        <= pend_grn_r;
      out_blue         <= pend_blu_r;
      out_frame_number <= pend_fn_r;
      out_frame_done   <= pend_fd_r;
      out_sprite_done  <= pend_sd_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_take_to_size: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == sprd_pkg::S_SIZE)
    else $error("byte taken but sequencer did not advance");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 3'd7)
    else $error("stream phase out of range");

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == sprd_pkg::PH_TRANS_LO)
    else $error("error stop with a run pair part-decoded");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == sprd_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_nonpixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != sprd_pkg::EV_PIXEL |->
      out_pixel_x == 8'd0 && out_pixel_y == 8'd0 && out_blue == 8'd0)
    else $error("non-pixel event carries placement or colour");

endmodule
